/* hdl/read_memory_size_profiler_assert.svh */
// Assertion macros for the read memory size profiler.
`ifndef READ_MEMORY_SIZE_PROFILER_ASSERT_SVH
`define READ_MEMORY_SIZE_PROFILER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RMSP_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("rmsp assertion failed");

// Next-cycle implication, checked out of reset.
`define RMSP_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("rmsp assertion failed");

`endif

/* hdl/rmsp_pkg.sv */
package rmsp_pkg;

  localparam int STACK_DEPTH      = 64;
  localparam int ADDR_BITS        = 16;
  localparam int MAX_ACCESS_BYTES = 8;
  localparam int FUNC_ID_BITS     = 16;

  localparam int IDX_W   = $clog2(STACK_DEPTH);
  localparam int TOP_W   = 7;
  localparam int TIME_W  = 32;
  localparam int RMS_W   = 32;
  localparam int LEN_W   = 4;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  localparam int IN_W  = 40;
  localparam int OUT_W = 96;

  localparam logic [CMD_W-1:0] CMD_CALL  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

/* hdl/read_memory_size_profiler.sv */
// Read memory size profiler. Keeps a shadow call stack (function id, entry
// time, rms) in three 64-entry frame memories and a 32-bit last-access
// timestamp per byte in a 64K-entry byte memory. One result transaction per
// input transaction. After reset the byte memory is swept to zero, one entry
// a cycle, while s_tready stays low. Reads and writes handle their bytes
// one at a time. A return adds the popped rms into the parent frame when
// there is one. A read scans the frames below the top, up to depth-1 per
// byte, when an older byte is reclaimed. The single read port of each
// memory, with its registered read data, sets this sequencing. The next
// input is taken while a finished result still waits in the output
// register.
`include "read_memory_size_profiler_assert.svh"

module read_memory_size_profiler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: cmd[1:0], func_id[17:2], addr[33:18], length[37:34], zero fill
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: status[1:0], ret_func_id[17:2], ret_entry_time[49:18],
  //          ret_rms[81:50], stack_depth[88:82], zero fill
  output logic [95:0] m_tdata
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_RET_A, S_RET_B, S_BYTE_RD, S_BYTE_CHK,
    S_SCAN, S_DONE
  } state_t;

  state_t state;

  // frame and byte memories
  logic [rmsp_pkg::FUNC_ID_BITS-1:0] frame_func [rmsp_pkg::STACK_DEPTH];
  logic [rmsp_pkg::TIME_W-1:0]       frame_time [rmsp_pkg::STACK_DEPTH];
  logic [rmsp_pkg::RMS_W-1:0]        frame_rms  [rmsp_pkg::STACK_DEPTH];
  logic [rmsp_pkg::TIME_W-1:0]       byte_mem   [2**rmsp_pkg::ADDR_BITS];

  // control registers
  logic [rmsp_pkg::TIME_W-1:0]    time_counter;
  logic [rmsp_pkg::TIME_W-1:0]    time_next;
  logic [rmsp_pkg::TOP_W-1:0]     stack_top;
  logic [rmsp_pkg::ADDR_BITS-1:0] clr_addr;
  logic [rmsp_pkg::CMD_W-1:0]     cmd;
  logic [rmsp_pkg::FUNC_ID_BITS-1:0] func_id;
  logic [rmsp_pkg::ADDR_BITS-1:0] addr;
  logic [rmsp_pkg::LEN_W-1:0]     length;
  logic [rmsp_pkg::LEN_W-1:0]     byte_n;
  logic [rmsp_pkg::IDX_W-1:0]     scan_idx;
  logic [rmsp_pkg::TIME_W-1:0]    seen;

  // result staging and output register
  logic [rmsp_pkg::STAT_W-1:0]       res_status;
  logic [rmsp_pkg::FUNC_ID_BITS-1:0] res_func;
  logic [rmsp_pkg::TIME_W-1:0]       res_time;
  logic [rmsp_pkg::RMS_W-1:0]        res_rms;

  // read data (registered)
  logic [rmsp_pkg::FUNC_ID_BITS-1:0] rd_func;
  logic [rmsp_pkg::TIME_W-1:0]       rd_time;
  logic [rmsp_pkg::RMS_W-1:0]        rd_rms;
  logic [rmsp_pkg::TIME_W-1:0]       rd_byte;

  // memory port controls
  logic [rmsp_pkg::IDX_W-1:0]     fr_raddr;
  logic [rmsp_pkg::IDX_W-1:0]     fr_waddr;
  logic                           push_we;
  logic                           rms_we;
  logic [rmsp_pkg::RMS_W-1:0]     rms_wdata;
  logic [rmsp_pkg::ADDR_BITS-1:0] bm_raddr;
  logic [rmsp_pkg::ADDR_BITS-1:0] bm_waddr;
  logic                           bm_we;
  logic [rmsp_pkg::TIME_W-1:0]    bm_wdata;

  logic [rmsp_pkg::IDX_W-1:0]     top_idx;
  logic [rmsp_pkg::ADDR_BITS-1:0] byte_addr;
  logic [rmsp_pkg::LEN_W-1:0]     in_len;
  logic                           charge;
  logic                           out_free;

  assign top_idx   = rmsp_pkg::IDX_W'(stack_top - rmsp_pkg::TOP_W'(1));
  assign byte_addr = addr + rmsp_pkg::ADDR_BITS'(byte_n);
  assign in_len    = (s_tdata[37:34] > rmsp_pkg::LEN_W'(rmsp_pkg::MAX_ACCESS_BYTES))
                   ? rmsp_pkg::LEN_W'(rmsp_pkg::MAX_ACCESS_BYTES) : s_tdata[37:34];
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  // saturating bump of the call counter
  assign time_next = (time_counter != '1) ? time_counter + rmsp_pkg::TIME_W'(1)
                                          : time_counter;
  // byte older than the top frame: charge it there
  assign charge    = (cmd == rmsp_pkg::CMD_READ) && (stack_top != '0) && (rd_byte < rd_time);

  // memory port steering
  always_comb begin
    fr_raddr  = top_idx;
    fr_waddr  = top_idx;
    push_we   = 1'b0;
    rms_we    = 1'b0;
    rms_wdata = rd_rms;
    bm_raddr  = byte_addr;
    bm_waddr  = byte_addr;
    bm_we     = 1'b0;
    bm_wdata  = time_counter;
    unique case (state)
      S_CLEAR: begin
        bm_waddr = clr_addr;
        bm_we    = 1'b1;
        bm_wdata = '0;
      end
      S_DISP: begin
        fr_waddr = stack_top[rmsp_pkg::IDX_W-1:0];
        push_we  = (cmd == rmsp_pkg::CMD_CALL)
                && (stack_top < rmsp_pkg::TOP_W'(rmsp_pkg::STACK_DEPTH));
      end
      S_RET_A: begin
        fr_raddr = top_idx - rmsp_pkg::IDX_W'(1);
      end
      S_RET_B: begin
        fr_waddr  = top_idx - rmsp_pkg::IDX_W'(1);
        rms_we    = 1'b1;
        rms_wdata = rd_rms + res_rms;
      end
      S_BYTE_CHK: begin
        bm_we     = 1'b1;
        rms_we    = charge;
        rms_wdata = rd_rms + rmsp_pkg::RMS_W'(1);
        fr_raddr  = top_idx - rmsp_pkg::IDX_W'(1);
      end
      S_SCAN: begin
        fr_waddr  = scan_idx;
        rms_we    = (rd_time <= seen);
        rms_wdata = rd_rms - rmsp_pkg::RMS_W'(1);
        fr_raddr  = scan_idx - rmsp_pkg::IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      frame_func[fr_waddr] <= func_id;
      frame_time[fr_waddr] <= time_next;
    end
    if (push_we) begin
      frame_rms[fr_waddr] <= '0;
    end else if (rms_we) begin
      frame_rms[fr_waddr] <= rms_wdata;
    end
    rd_func <= frame_func[fr_raddr];
    rd_time <= frame_time[fr_raddr];
    rd_rms  <= frame_rms[fr_raddr];
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      byte_mem[bm_waddr] <= bm_wdata;
    end
    rd_byte <= byte_mem[bm_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      time_counter <= '0;
      stack_top    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + rmsp_pkg::ADDR_BITS'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd     <= s_tdata[1:0];
            func_id <= s_tdata[17:2];
            addr    <= s_tdata[33:18];
            length  <= in_len;
            state   <= S_DISP;
          end
        end
        S_DISP: begin
          res_status <= rmsp_pkg::ST_OK;
          res_func   <= '0;
          res_time   <= '0;
          res_rms    <= '0;
          byte_n     <= '0;
          case (cmd)
            rmsp_pkg::CMD_CALL: begin
              // the pushed frame takes the bumped counter value
              state <= S_DONE;
              if (stack_top >= rmsp_pkg::TOP_W'(rmsp_pkg::STACK_DEPTH)) begin
                res_status <= rmsp_pkg::ST_FULL;
              end else begin
                stack_top <= stack_top + rmsp_pkg::TOP_W'(1);
              end
              time_counter <= time_next;
            end
            rmsp_pkg::CMD_RET: begin
              if (stack_top == '0) begin
                res_status <= rmsp_pkg::ST_EMPTY;
                state      <= S_DONE;
              end else begin
                state <= S_RET_A;
              end
            end
            default: begin
              if (cmd == rmsp_pkg::CMD_READ && stack_top == '0) begin
                res_status <= rmsp_pkg::ST_EMPTY;
              end
              state <= (length == '0) ? S_DONE : S_BYTE_RD;
            end
          endcase
        end
        S_RET_A: begin
          res_func <= rd_func;
          res_time <= rd_time;
          res_rms  <= rd_rms;
          if (top_idx == '0) begin
            stack_top <= stack_top - rmsp_pkg::TOP_W'(1);
            state     <= S_DONE;
          end else begin
            state <= S_RET_B;
          end
        end
        S_RET_B: begin
          stack_top <= stack_top - rmsp_pkg::TOP_W'(1);
          state     <= S_DONE;
        end
        S_BYTE_RD: begin
          state <= S_BYTE_CHK;
        end
        S_BYTE_CHK: begin
          seen     <= rd_byte;
          scan_idx <= top_idx - rmsp_pkg::IDX_W'(1);
          // look for the newest frame live at the byte's earlier access
          if (charge && rd_byte != '0 && top_idx != '0) begin
            state <= S_SCAN;
          end else begin
            byte_n <= byte_n + rmsp_pkg::LEN_W'(1);
            state  <= (byte_n + rmsp_pkg::LEN_W'(1) == length) ? S_DONE : S_BYTE_RD;
          end
        end
        S_SCAN: begin
          if (rd_time <= seen || scan_idx == '0) begin
            byte_n <= byte_n + rmsp_pkg::LEN_W'(1);
            state  <= (byte_n + rmsp_pkg::LEN_W'(1) == length) ? S_DONE : S_BYTE_RD;
          end else begin
            scan_idx <= scan_idx - rmsp_pkg::IDX_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata[1:0]    <= res_status;
            m_tdata[17:2]   <= res_func;
            m_tdata[49:18]  <= res_time;
            m_tdata[81:50]  <= res_rms;
            m_tdata[88:82]  <= stack_top;
            m_tdata[95:89]  <= '0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RMSP_ASSERT_IMPLY(a_top_bound, clk, rst, 1'b1, stack_top <= rmsp_pkg::TOP_W'(rmsp_pkg::STACK_DEPTH))
  `RMSP_ASSERT_IMPLY(a_scan_below_top, clk, rst, state == S_SCAN, scan_idx < top_idx && stack_top != '0)
  `RMSP_ASSERT_NEXT(a_done_wait, clk, rst, state == S_DONE && !out_free, state == S_DONE && m_tvalid)

endmodule

/* test/read_memory_size_profiler_tb.sv */
`timescale 1ns / 1ps

module read_memory_size_profiler_tb;

  typedef struct packed {
    logic [rmsp_pkg::STAT_W-1:0] status;
    logic [15:0]       func_id;
    logic [31:0]       entry_time;
    logic [31:0]       rms;
    logic [6:0]        depth;
  } profile_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;

  read_memory_size_profiler u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Shadow profiler state
  logic [31:0] shadow_time;
  int          shadow_depth;
  logic [15:0] shadow_func [0:rmsp_pkg::STACK_DEPTH-1];
  logic [31:0] shadow_entry [0:rmsp_pkg::STACK_DEPTH-1];
  logic [31:0] shadow_rms [0:rmsp_pkg::STACK_DEPTH-1];
  logic [31:0] byte_stamp [0:65535];

  profile_result_t pending_results[$];
  int  mismatches;
  int  results_seen;
  int  items_sent;
  int  reclaims;
  int  full_hits;
  int  send_idle_pct;
  int  recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Apply one read or write to the byte stamps; read also charges rms.
  function automatic void touch_bytes(logic [15:0] addr, int len, bit is_read);
    logic [15:0] a;
    logic [31:0] seen;
    int top;
    int l;
    for (int n = 0; n < len; n++) begin
      a = addr + 16'(n);
      seen = byte_stamp[a];
      if (is_read && shadow_depth > 0) begin
        top = shadow_depth - 1;
        if (seen < shadow_entry[top]) begin
          shadow_rms[top] += 1;
          // Give the byte back from the newest frame live at its last touch
          if (seen != 0) begin
            for (l = top; l >= 0; l--) begin
              if (shadow_entry[l] <= seen) begin
                shadow_rms[l] -= 1;
                reclaims++;
                break;
              end
            end
          end
        end
      end
      byte_stamp[a] = shadow_time;
    end
  endfunction

  function automatic profile_result_t predict_profile(logic [1:0] cmd, logic [15:0] fid,
                                                     logic [15:0] addr, logic [3:0] len_in);
    profile_result_t r;
    int len;
    int top;
    r = '0;
    r.status = rmsp_pkg::ST_OK;
    len = (len_in > rmsp_pkg::MAX_ACCESS_BYTES) ? rmsp_pkg::MAX_ACCESS_BYTES : int'(len_in);
    case (cmd)
      rmsp_pkg::CMD_CALL: begin
        if (shadow_time != 32'hFFFF_FFFF) shadow_time++;
        if (shadow_depth >= rmsp_pkg::STACK_DEPTH) begin
          r.status = rmsp_pkg::ST_FULL;
          full_hits++;
        end else begin
          shadow_func[shadow_depth] = fid;
          shadow_entry[shadow_depth] = shadow_time;
          shadow_rms[shadow_depth] = '0;
          shadow_depth++;
        end
      end
      rmsp_pkg::CMD_RET: begin
        if (shadow_depth == 0) begin
          r.status = rmsp_pkg::ST_EMPTY;
        end else begin
          top = shadow_depth - 1;
          // bottom frame's rms goes nowhere
          if (top > 0) shadow_rms[top-1] += shadow_rms[top];
          r.func_id = shadow_func[top];
          r.entry_time = shadow_entry[top];
          r.rms = shadow_rms[top];
          shadow_depth = top;
        end
      end
      rmsp_pkg::CMD_READ: begin
        if (shadow_depth == 0) r.status = rmsp_pkg::ST_EMPTY;
        touch_bytes(addr, len, 1'b1);
      end
      default: touch_bytes(addr, len, 1'b0);
    endcase
    r.depth = 7'(shadow_depth);
    return r;
  endfunction

  // Drive one transaction; prediction happens at the accepting edge.
  task automatic send_item(logic [1:0] cmd, logic [15:0] fid, logic [15:0] addr,
                           logic [3:0] len);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, len, addr, fid, cmd};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_profile(cmd, fid, addr, len));
    items_sent++;
  endtask

  // Receiver: random stalls, in-order compare against predictions
  always @(posedge clk) begin
    profile_result_t got;
    profile_result_t want;
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[1:0], m_tdata[17:2], m_tdata[49:18], m_tdata[81:50], m_tdata[88:82]};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch #%0d: exp st=%0d fid=%h t=%h rms=%h d=%0d",
                      " | got st=%0d fid=%h t=%h rms=%h d=%0d"},
                     results_seen, want.status, want.func_id, want.entry_time, want.rms,
                     want.depth, got.status, got.func_id, got.entry_time, got.rms, got.depth);
        end
      end
    end
  end

  function automatic logic [15:0] pick_addr();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(127));
    if (r < 80) return 16'($urandom_range(16'hFFFF, 16'hFFF0));
    return 16'($urandom);
  endfunction

  // Empty stack cases, then nesting with a reclaimed byte, length and wrap extremes
  task automatic test_directed();
    send_item(rmsp_pkg::CMD_RET, 16'h0, 16'h0, 4'd0);
    send_item(rmsp_pkg::CMD_READ, 16'h0, 16'h0010, 4'd4);
    send_item(rmsp_pkg::CMD_WRITE, 16'h0, 16'h0020, 4'd2);
    send_item(rmsp_pkg::CMD_CALL, 16'h0000, 16'h0, 4'd0);
    send_item(rmsp_pkg::CMD_READ, 16'h0, 16'h0010, 4'd8);   // earlier stamps are still zero: all bytes charged
    send_item(rmsp_pkg::CMD_CALL, 16'hFFFF, 16'hFFFF, 4'd15);
    send_item(rmsp_pkg::CMD_READ, 16'h0, 16'h0012, 4'd4);   // parent gives bytes back
    send_item(rmsp_pkg::CMD_READ, 16'h0, 16'h0012, 4'd4);   // already own: no charge
    send_item(rmsp_pkg::CMD_WRITE, 16'h0, 16'hFFFE, 4'd15); // length saturates, wraps to 0
    send_item(rmsp_pkg::CMD_READ, 16'h0, 16'hFFFC, 4'd8);
    send_item(rmsp_pkg::CMD_READ, 16'h0, 16'h5555, 4'd0);
    send_item(rmsp_pkg::CMD_CALL, 16'hAAAA, 16'hAAAA, 4'd10);
    send_item(rmsp_pkg::CMD_READ, 16'h0, 16'h0020, 4'd2);   // older than any live frame
    send_item(rmsp_pkg::CMD_RET, 16'h0, 16'h0, 4'd0);
    send_item(rmsp_pkg::CMD_RET, 16'h0, 16'h0, 4'd0);
    send_item(rmsp_pkg::CMD_RET, 16'h0, 16'h0, 4'd0);       // bottom frame
    send_item(rmsp_pkg::CMD_RET, 16'h0, 16'h0, 4'd0);
    send_item(rmsp_pkg::CMD_WRITE, 16'h0, 16'hFFFF, 4'd9);
  endtask

  // Fill the stack, overflow it, then deep reads before unwinding
  task automatic test_stack_full();
    for (int i = 0; i < rmsp_pkg::STACK_DEPTH + 2; i++) begin
      send_item(rmsp_pkg::CMD_CALL, 16'($urandom), 16'h0, 4'd0);
      if (i % 16 == 0) send_item(rmsp_pkg::CMD_READ, 16'h0, 16'h0040, 4'd8);
    end
    send_item(rmsp_pkg::CMD_READ, 16'h0, 16'h0040, 4'd8);
    for (int i = 0; i < rmsp_pkg::STACK_DEPTH + 1; i++)
      send_item(rmsp_pkg::CMD_RET, 16'h0, 16'h0, 4'd0);
  endtask

  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (shadow_depth == 0 && r < 60) r = 0;
      if (r < 30)
        send_item(rmsp_pkg::CMD_CALL, 16'($urandom), 16'($urandom), 4'($urandom));
      else if (r < 50)
        send_item(rmsp_pkg::CMD_RET, 16'($urandom), 16'($urandom), 4'($urandom));
      else if (r < 85)
        send_item(rmsp_pkg::CMD_READ, 16'($urandom), pick_addr(), 4'($urandom_range(15)));
      else
        send_item(rmsp_pkg::CMD_WRITE, 16'($urandom), pick_addr(), 4'($urandom_range(15)));
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    shadow_time = '0;
    shadow_depth = 0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    reclaims = 0;
    full_hits = 0;
    send_idle_pct = 8;
    recv_idle_pct = 68;
    for (int i = 0; i < rmsp_pkg::STACK_DEPTH; i++) begin
      shadow_func[i] = '0;
      shadow_entry[i] = '0;
      shadow_rms[i] = '0;
    end
    for (int i = 0; i < 65536; i++) byte_stamp[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_stack_full();
    test_random(650);
    send_idle_pct = 68;
    recv_idle_pct = 8;
    test_random(650);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(650);
    drain();
    repeat (1000) @(posedge clk);

    $display("Covered %0d transactions (%0d results), %0d byte reclaims, %0d overflowing calls",
             items_sent, results_seen, reclaims, full_hits);
    $display("Mismatches: %0d, results still outstanding: %0d", mismatches,
             pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/rmsp_pkg.sv
hdl/read_memory_size_profiler.sv
test/read_memory_size_profiler_tb.sv
